// ----- hw/rtl/handshake_keyword_sequencer_macros.svh -----
// Assertion macros for the handshake keyword sequencer RTL.
// Uses clk_i and rst_ni from the including module; no other dependencies.
`ifndef HANDSHAKE_KEYWORD_SEQUENCER_MACROS_SVH
`define HANDSHAKE_KEYWORD_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define HKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define HKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define HKS_ASSERT(lbl, prop, msg)
`define HKS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/hks_pkg.sv -----
// Shared types, constants and keyword tables for the handshake keyword sequencer.
// No dependencies.
package hks_pkg;

  localparam int WINDOW_LEN = 7;
  localparam int KW_NUM     = 5;
  localparam int KW_MAX     = 7;

  typedef logic [7:0] byte_t;
  typedef logic [WINDOW_LEN-1:0][7:0] window_t;  // [0] is the oldest byte
  typedef logic [2:0] phase_code_t;
  typedef logic [2:0] act_code_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_LOST    = 2'd1,
    KIND_CONNECT = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    S_INIT        = 7'b0000001,
    S_AUTH        = 7'b0000010,
    S_AUTH_STREAM = 7'b0000100,
    S_BIND        = 7'b0001000,
    S_SESSION     = 7'b0010000,
    S_READY       = 7'b0100000,
    S_WAIT        = 7'b1000000
  } phase_e;

  localparam phase_code_t PH_INIT        = 3'd0;
  localparam phase_code_t PH_AUTH        = 3'd1;
  localparam phase_code_t PH_AUTH_STREAM = 3'd2;
  localparam phase_code_t PH_BIND        = 3'd3;
  localparam phase_code_t PH_SESSION     = 3'd4;
  localparam phase_code_t PH_READY       = 3'd5;
  localparam phase_code_t PH_WAIT        = 3'd6;

  localparam act_code_t ACT_NONE    = 3'd0;
  localparam act_code_t ACT_STREAM  = 3'd1;
  localparam act_code_t ACT_AUTH    = 3'd2;
  localparam act_code_t ACT_BIND    = 3'd3;
  localparam act_code_t ACT_SESSION = 3'd4;
  localparam act_code_t ACT_READY   = 3'd5;

  // Keyword slots, one per searching phase
  localparam int KW_PLAIN   = 0;
  localparam int KW_SUCCESS = 1;
  localparam int KW_BIND    = 2;
  localparam int KW_JID     = 3;
  localparam int KW_RESULT  = 4;

  localparam int KW_LEN [KW_NUM] = '{5, 7, 4, 3, 6};

  localparam byte_t KW_TEXT [KW_NUM][KW_MAX] = '{
    '{8'h50, 8'h4C, 8'h41, 8'h49, 8'h4E, 8'h00, 8'h00},  // PLAIN
    '{8'h73, 8'h75, 8'h63, 8'h63, 8'h65, 8'h73, 8'h73},  // success
    '{8'h62, 8'h69, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00},  // bind
    '{8'h6A, 8'h69, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},  // jid
    '{8'h72, 8'h65, 8'h73, 8'h75, 8'h6C, 8'h74, 8'h00}   // result
  };

  typedef struct packed {
    phase_code_t phase;
    logic        advanced;
    act_code_t   action;
  } res_t;

  function automatic phase_code_t phase_code(phase_e ph);
    phase_code_t code;
    case (ph)
      S_INIT:        code = PH_INIT;
      S_AUTH:        code = PH_AUTH;
      S_AUTH_STREAM: code = PH_AUTH_STREAM;
      S_BIND:        code = PH_BIND;
      S_SESSION:     code = PH_SESSION;
      S_READY:       code = PH_READY;
      S_WAIT:        code = PH_WAIT;
      default:       code = PH_INIT;
    endcase
    return code;
  endfunction

  function automatic act_code_t entry_action(phase_e ph);
    act_code_t act;
    case (ph)
      S_INIT:        act = ACT_STREAM;
      S_AUTH:        act = ACT_AUTH;
      S_AUTH_STREAM: act = ACT_STREAM;
      S_BIND:        act = ACT_BIND;
      S_SESSION:     act = ACT_SESSION;
      S_READY:       act = ACT_READY;
      default:       act = ACT_NONE;
    endcase
    return act;
  endfunction

endpackage

// ----- hw/rtl/hks_match.sv -----
// Parallel keyword search over the receive window, all offsets at once.
// Depends on hks_pkg.
module hks_match import hks_pkg::*; (
  input  window_t           win_i,
  output logic [KW_NUM-1:0] hit_o
);

  logic [WINDOW_LEN-1:0] nz_pre;
  logic                  m;

  always_comb begin
    // nz_pre[j]: bytes 0..j are all nonzero (search stops at first zero)
    nz_pre[0] = (win_i[0] != 8'h00);
    for (int j = 1; j < WINDOW_LEN; j++) begin
      nz_pre[j] = nz_pre[j-1] && (win_i[j] != 8'h00);
    end

    hit_o = '0;
    m     = 1'b0;
    for (int p = 0; p < KW_NUM; p++) begin
      for (int s = 0; s + KW_LEN[p] <= WINDOW_LEN; s++) begin
        m = nz_pre[s + KW_LEN[p] - 1];
        for (int k = 0; k < KW_LEN[p]; k++) begin
          m = m && (win_i[s + k] == KW_TEXT[p][k]);
        end
        hit_o[p] = hit_o[p] | m;
      end
    end
  end

endmodule

// ----- hw/rtl/hks_seq.sv -----
// Window and phase state with next-state logic for one request per cycle while take_i is high.
// Depends on hks_pkg, hks_match and the assertion macro header.
`include "handshake_keyword_sequencer_macros.svh"

module hks_seq import hks_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  take_i,
  input  kind_e kind_i,
  input  byte_t rx_byte_i,
  output res_t  res_o
);

  window_t           window_q, window_d, shifted;
  phase_e            phase_q, phase_d;
  logic [KW_NUM-1:0] hit;
  act_code_t         act;

  hks_match u_match (
    .win_i (shifted),
    .hit_o (hit)
  );

  always_comb begin
    shifted[WINDOW_LEN-2:0] = window_q[WINDOW_LEN-1:1];
    shifted[WINDOW_LEN-1]   = rx_byte_i;
  end

  always_comb begin
    window_d = window_q;
    phase_d  = phase_q;
    act      = ACT_NONE;
    case (kind_i)
      KIND_LOST: begin
        window_d = '0;
        phase_d  = S_WAIT;
      end
      KIND_CONNECT: begin
        window_d = '0;
        phase_d  = S_INIT;
        act      = entry_action(S_INIT);
      end
      KIND_BYTE: begin
        window_d = shifted;
        if (shifted[0] != 8'h00) begin
          case (phase_q)
            S_INIT:        if (hit[KW_PLAIN]) phase_d = S_AUTH;
            S_AUTH:        if (hit[KW_SUCCESS]) phase_d = S_AUTH_STREAM;
            S_AUTH_STREAM: if (hit[KW_BIND]) phase_d = S_BIND;
            S_BIND:        if (hit[KW_JID]) phase_d = S_SESSION;
            S_SESSION:     if (hit[KW_RESULT]) phase_d = S_READY;
            S_READY:       phase_d = S_WAIT;
            default:       phase_d = phase_q;
          endcase
          if (phase_d != phase_q) begin
            window_d = '0;
            act      = entry_action(phase_d);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.phase    = phase_code(phase_d);
    res_o.advanced = (phase_d != phase_q);
    res_o.action   = act;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      phase_q  <= S_INIT;
    end else if (take_i) begin
      window_q <= window_d;
      phase_q  <= phase_d;
    end
  end

  `HKS_ASSERT(a_lost_clears, take_i && kind_i == KIND_LOST |=> phase_q == S_WAIT && window_q == '0, "connection loss did not force wait")
  `HKS_ASSERT(a_adv_clears, take_i && kind_i == KIND_BYTE && res_o.advanced |=> window_q == '0, "window not cleared on phase change")
  `HKS_ASSERT(a_idle_holds, !take_i |=> $stable(phase_q) && $stable(window_q), "state moved without a request")
  `HKS_ASSERT(a_connect_act, take_i && kind_i == KIND_CONNECT |-> res_o.action == ACT_STREAM && res_o.phase == PH_INIT, "connect result wrong")

endmodule

// ----- hw/rtl/handshake_keyword_sequencer.sv -----
// Top level of the handshake keyword sequencer: input register, state, result register.
// Depends on hks_pkg, hks_seq and the assertion macro header.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------
//   in      | in_valid_i / in_ready_o | kind_i, rx_byte_i
//   out     | out_valid_o/out_ready_i | phase_o, advanced_o, action_o
//
// Throughput is one request per cycle while the output is not stalled; a taken request
// passes the input register, then the result register, before its result is on the
// outputs, where it is taken at an edge with out_ready_i high.
// All keyword offsets are compared in parallel and combinationally from the input register.
// Reset (rst_ni low) clears the window, sets the phase to init and empties both registers.
// A stalled output holds its result; the input register keeps taking requests
// while it is empty or its request moves into a free or draining result register.
`include "handshake_keyword_sequencer_macros.svh"

module handshake_keyword_sequencer import hks_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  phase_o,
  output logic        advanced_o,
  output logic [2:0]  action_o
);

  logic        in_valid_q;
  kind_e       kind_q;
  byte_t       rx_byte_q;
  logic        out_valid_q;
  res_t        res_q, res_d;
  logic        advance;

  // process the held request when the result register can take it
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  hks_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (advance),
    .kind_i    (kind_q),
    .rx_byte_i (rx_byte_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q    <= kind_e'(kind_i);
      rx_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phase_o     = res_q.phase;
  assign advanced_o  = res_q.advanced;
  assign action_o    = res_q.action;

  `HKS_ASSERT(a_adv_loads, advance |=> out_valid_q, "processed request produced no result")
  `HKS_ASSERT(a_take_loads, in_valid_i && in_ready_o |=> in_valid_q, "accepted request was dropped")
  `HKS_ASSERT(a_no_overwrite, out_valid_q && !out_ready_i |-> !advance, "pending result overwritten")
  `HKS_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_q && !in_valid_q, "registers not empty in reset")

endmodule
